FILE: rtl/akf_pkg.sv
package akf_pkg;

  localparam int COV_FRAC_BITS = 24;
  localparam int NOISE_FRAC    = 24;
  localparam int NOISE_SHL     = (COV_FRAC_BITS >= NOISE_FRAC) ? COV_FRAC_BITS - NOISE_FRAC : 0;
  localparam int NOISE_SHR     = (COV_FRAC_BITS < NOISE_FRAC) ? NOISE_FRAC - COV_FRAC_BITS : 1;

  localparam int NUM_W  = 62;   // |P| * 2^30
  localparam int DEN_W  = 33;   // |S|
  localparam int DIV_CW = 6;

  localparam logic [23:0] ANGLE_NOISE_RST = 24'd167772;
  localparam logic [23:0] BIAS_NOISE_RST  = 24'd503316;
  localparam logic [23:0] MEAS_NOISE_RST  = 24'd1677722;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_RESTART, OP_RATE, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_DIVST, OP_GAIN,
    OP_C1, OP_C2, OP_C3, OP_C4, OP_C5, OP_C6, OP_C7, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

  // Noise register (Q0.24) to covariance format.
  function automatic logic signed [31:0] noise_to_cov(input logic [23:0] q);
    logic [31:0] v;
    begin
      v = {8'd0, q};
      if (COV_FRAC_BITS >= NOISE_FRAC) begin
        noise_to_cov = signed'(v << NOISE_SHL);
      end else begin
        noise_to_cov = signed'((v + (32'd1 << (NOISE_SHR - 1))) >> NOISE_SHR);
      end
    end
  endfunction

endpackage

FILE: rtl/akf_div.sv
module akf_div
  import akf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num0,
  input  logic [NUM_W-1:0] num1,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo0,
  output logic [NUM_W-1:0] quo1,
  output logic             done
);

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DEN_W-1:0]  dreg;
  logic [DEN_W-1:0]  rem0, rem1;
  logic [DEN_W:0]    sh0, sh1;
  logic              ge0, ge1;

  // Restoring division, one quotient bit per lane each cycle; the numerator
  // register fills up with the quotient.
  assign sh0 = {rem0, quo0[NUM_W-1]};
  assign sh1 = {rem1, quo1[NUM_W-1]};
  assign ge0 = sh0 >= {1'b0, dreg};
  assign ge1 = sh1 >= {1'b0, dreg};
  assign done = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CW'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo0 <= num0;
      quo1 <= num1;
      rem0 <= '0;
      rem1 <= '0;
      dreg <= den;
    end else if (busy) begin
      rem0 <= ge0 ? DEN_W'(sh0 - {1'b0, dreg}) : sh0[DEN_W-1:0];
      rem1 <= ge1 ? DEN_W'(sh1 - {1'b0, dreg}) : sh1[DEN_W-1:0];
      quo0 <= {quo0[NUM_W-2:0], ge0};
      quo1 <= {quo1[NUM_W-2:0], ge1};
    end
  end

endmodule

FILE: rtl/akf_datapath.sv
module akf_datapath
  import akf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [87:0] s_tdata,
  input  logic [23:0] angle_process_noise,
  input  logic [23:0] bias_process_noise,
  input  logic [23:0] measurement_noise,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata
);

  logic signed [31:0] meas, gyro, rate, y, k0, k1;
  logic        [23:0] dt;
  logic signed [31:0] angle, bias, p00, p01, p10, p11;
  logic signed [35:0] inner;
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b, dt_s;
  logic signed [68:0] prod;
  logic signed [71:0] prod_w, t24, t30, t_pred;
  logic signed [31:0] qa, qb, r;
  logic signed [32:0] s;
  logic        [DEN_W-1:0] s_mag;
  logic        [31:0] m00, m10;
  logic        [NUM_W-1:0] quo0, quo1;
  logic        neg0, neg1, s_zero;
  logic        div_done;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    begin
      if (v > 72'sd2147483647) begin
        sat32 = 32'sh7fffffff;
      end else if (v < -72'sd2147483648) begin
        sat32 = 32'sh80000000;
      end else begin
        sat32 = v[31:0];
      end
    end
  endfunction

  function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v, input int sh);
    logic signed [71:0] t;
    begin
      t = v + (72'sd1 <<< (sh - 1));
      rnd_shr = t >>> sh;
    end
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    begin
      mag32 = v[31] ? 32'(-v) : 32'(v);
    end
  endfunction

  function automatic logic signed [31:0] gain_fin(input logic [NUM_W-1:0] q,
                                                  input logic neg, input logic zero);
    begin
      if (zero) begin
        gain_fin = '0;
      end else if (!neg) begin
        gain_fin = (q[NUM_W-1:31] != '0) ? 32'sh7fffffff : signed'(q[31:0]);
      end else if (q[NUM_W-1:32] != '0 || (q[31] && q[30:0] != '0)) begin
        gain_fin = 32'sh80000000;
      end else begin
        gain_fin = signed'(32'(-q[31:0]));
      end
    end
  endfunction

  assign qa   = noise_to_cov(angle_process_noise);
  assign qb   = noise_to_cov(bias_process_noise);
  assign r    = noise_to_cov(measurement_noise);
  assign dt_s = signed'({9'd0, dt});

  assign s      = 33'(p00) + 33'(r);
  assign s_mag  = s[32] ? DEN_W'(-s) : DEN_W'(s);
  assign m00    = mag32(p00);
  assign m10    = mag32(p10);

  assign prod_w = 72'(prod);
  assign t24    = rnd_shr(prod_w, 24);
  assign t30    = rnd_shr(prod_w, 30);
  assign t_pred = t24;

  always_comb begin
    mul_a = 36'(rate);
    mul_b = dt_s;
    case (cmd.op)
      OP_M1: begin mul_a = 36'(rate); mul_b = dt_s; end
      OP_M2: begin mul_a = 36'(p11);  mul_b = dt_s; end
      OP_M3: begin mul_a = 36'(qb);   mul_b = dt_s; end
      OP_M4: begin mul_a = inner;     mul_b = dt_s; end
      OP_C1: begin mul_a = 36'(y);    mul_b = 33'(k0); end
      OP_C2: begin mul_a = 36'(y);    mul_b = 33'(k1); end
      OP_C3: begin mul_a = 36'(p00);  mul_b = 33'(k1); end
      OP_C4: begin mul_a = 36'(p00);  mul_b = 33'(k0); end
      OP_C5: begin mul_a = 36'(p01);  mul_b = 33'(k1); end
      OP_C6: begin mul_a = 36'(p01);  mul_b = 33'(k0); end
      default: begin mul_a = 36'(rate); mul_b = dt_s; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  akf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.op == OP_DIVST),
    .num0 ({m00, 30'd0}),
    .num1 ({m10, 30'd0}),
    .den  (s_mag),
    .quo0 (quo0),
    .quo1 (quo1),
    .done (div_done)
  );

  // Estimates and covariance are updated in place; the product order keeps
  // every predicted value alive until its last use.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      p00   <= '0;
      p01   <= '0;
      p10   <= '0;
      p11   <= '0;
    end else begin
      case (cmd.op)
        OP_RESTART: begin
          angle <= meas;
          bias  <= '0;
          p00   <= '0;
          p01   <= '0;
          p10   <= '0;
          p11   <= '0;
        end
        OP_M2: angle <= sat32(72'(angle) + t_pred);
        OP_M3: begin
          p01 <= sat32(72'(p01) - t_pred);
          p10 <= sat32(72'(p10) - t_pred);
        end
        OP_M4: p11   <= sat32(72'(p11) + t_pred);
        OP_M5: p00   <= sat32(72'(p00) + t_pred);
        OP_C2: angle <= sat32(72'(angle) + t30);
        OP_C3: bias  <= sat32(72'(bias) + t30);
        OP_C4: p10   <= sat32(72'(p10) - t30);
        OP_C5: p00   <= sat32(72'(p00) - t30);
        OP_C6: p11   <= sat32(72'(p11) - t30);
        OP_C7: p01   <= sat32(72'(p01) - t30);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas <= signed'(s_tdata[31:0]);
      gyro <= signed'(s_tdata[63:32]);
      dt   <= s_tdata[87:64];
    end
    case (cmd.op)
      OP_RESTART: rate <= gyro;
      OP_RATE:    rate <= sat32(72'(gyro) - 72'(bias));
      OP_M3:      inner <= 36'(t24 - 72'(p01) - 72'(p10) + 72'(qa));
      OP_DIVST: begin
        y      <= sat32(72'(meas) - 72'(angle));
        neg0   <= p00[31] ^ s[32];
        neg1   <= p10[31] ^ s[32];
        s_zero <= (s == '0);
      end
      OP_GAIN: begin
        k0 <= gain_fin(quo0, neg0, s_zero);
        k1 <= gain_fin(quo1, neg1, s_zero);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      m_tdata <= {rate, angle};
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !m_tvalid;

endmodule

FILE: rtl/akf_ctrl.sv
module akf_ctrl
  import akf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tuser,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_RESTART, ST_RATE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_DIVST, ST_DIVW,
    ST_GAIN, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_FINISH
  } state_t;

  state_t state;
  op_t    op;

  assign s_tready = (state == ST_IDLE);
  assign cmd.op   = op;
  assign cmd.load = s_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_NONE;
    end else begin
      op <= OP_NONE;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              state <= ST_RESTART;
              op    <= OP_RESTART;
            end else begin
              state <= ST_RATE;
              op    <= OP_RATE;
            end
          end
        end
        ST_RESTART: state <= ST_FINISH;
        ST_RATE:  begin state <= ST_M1;    op <= OP_M1;    end
        ST_M1:    begin state <= ST_M2;    op <= OP_M2;    end
        ST_M2:    begin state <= ST_M3;    op <= OP_M3;    end
        ST_M3:    begin state <= ST_M4;    op <= OP_M4;    end
        ST_M4:    begin state <= ST_M5;    op <= OP_M5;    end
        ST_M5:    begin state <= ST_DIVST; op <= OP_DIVST; end
        ST_DIVST: state <= ST_DIVW;
        ST_DIVW: begin
          if (status.div_done) begin
            state <= ST_GAIN;
            op    <= OP_GAIN;
          end
        end
        ST_GAIN:  begin state <= ST_C1; op <= OP_C1; end
        ST_C1:    begin state <= ST_C2; op <= OP_C2; end
        ST_C2:    begin state <= ST_C3; op <= OP_C3; end
        ST_C3:    begin state <= ST_C4; op <= OP_C4; end
        ST_C4:    begin state <= ST_C5; op <= OP_C5; end
        ST_C5:    begin state <= ST_C6; op <= OP_C6; end
        ST_C6:    begin state <= ST_C7; op <= OP_C7; end
        ST_C7:    state <= ST_FINISH;
        ST_FINISH: begin
          if (status.out_free) begin
            state <= ST_IDLE;
            op    <= OP_OUT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/angle_kalman_filter_1d.sv
// Two-state angle and gyro-bias Kalman filter in fixed point. An update item
// (tuser = 0) waits on the bit-serial divider, which forms a 62-bit quotient
// for both gains at once; its other steps go one at a time through one shared
// registered multiplier, plus the output hand-off. A restart item (tuser = 1)
// loads the angle and clears bias and covariance. One item is processed at a
// time, and the next item can be accepted in the cycle its result is loaded. A
// result that has not been taken holds the following item at its last step
// until the result register is free. Noise registers sit on the APB port at
// byte addresses 0, 4 and 8 and should be written while idle.
module angle_kalman_filter_1d
  import akf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // measured_angle, gyro_rate, time_step
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // filtered_angle, corrected_rate
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [23:0] angle_process_noise, bias_process_noise, measurement_noise;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_process_noise <= ANGLE_NOISE_RST;
      bias_process_noise  <= BIAS_NOISE_RST;
      measurement_noise   <= MEAS_NOISE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ANGLE_NOISE: angle_process_noise <= pwdata[23:0];
        REG_BIAS_NOISE:  bias_process_noise  <= pwdata[23:0];
        REG_MEAS_NOISE:  measurement_noise   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ANGLE_NOISE: prdata = {8'd0, angle_process_noise};
      REG_BIAS_NOISE:  prdata = {8'd0, bias_process_noise};
      REG_MEAS_NOISE:  prdata = {8'd0, measurement_noise};
      default:         prdata = '0;
    endcase
  end

  akf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tuser (s_tuser),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  akf_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .s_tdata            (s_tdata),
    .angle_process_noise(angle_process_noise),
    .bias_process_noise (bias_process_noise),
    .measurement_noise  (measurement_noise),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata)
  );

endmodule

FILE: dv/akf_checker.sv
`timescale 1ns / 1ps

module akf_checker
  import akf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,   // measured_angle, gyro_rate, time_step
  input  logic        s_tuser,   // mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // filtered_angle, corrected_rate
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } filt_out_t;

  filt_out_t  expected_q[$];
  logic [23:0] q_angle, q_bias, r_meas;
  longint     ang, bias, p00, p01, p10, p11;

  assign pending = expected_q.size();

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rescale with rounding to nearest, ties toward plus infinity.
  function automatic longint rnd_shr(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint to_cov(input logic [23:0] q);
    longint v;
    v = longint'({40'd0, q});
    if (COV_FRAC_BITS >= 24) return v <<< (COV_FRAC_BITS - 24);
    return rnd_shr(v, 24 - COV_FRAC_BITS);
  endfunction

  function automatic longint kgain(input longint p, input longint s);
    if (s == 0) return 0;
    return sat32((p <<< 30) / s);
  endfunction

  function automatic filt_out_t filter_step(input logic mode, input logic [87:0] d);
    longint meas, gyro, dt, rate, qa, qb, r, inner, s, k0, k1, y;
    longint n00, n01, n10, n11;
    filt_out_t res;
    meas = longint'(signed'(d[31:0]));
    gyro = longint'(signed'(d[63:32]));
    dt   = longint'({40'd0, d[87:64]});
    if (mode) begin
      ang = meas; bias = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
      rate = gyro;
    end else begin
      qa = to_cov(q_angle);
      qb = to_cov(q_bias);
      r  = to_cov(r_meas);
      rate = sat32(gyro - bias);
      ang  = sat32(ang + rnd_shr(dt * rate, 24));
      inner = rnd_shr(dt * p11, 24) - p01 - p10 + qa;
      n00 = sat32(p00 + rnd_shr(dt * inner, 24));
      n01 = sat32(p01 - rnd_shr(dt * p11, 24));
      n10 = sat32(p10 - rnd_shr(dt * p11, 24));
      n11 = sat32(p11 + rnd_shr(qb * dt, 24));
      s  = n00 + r;
      k0 = kgain(n00, s);
      k1 = kgain(n10, s);
      y = sat32(meas - ang);
      ang  = sat32(ang + rnd_shr(k0 * y, 30));
      bias = sat32(bias + rnd_shr(k1 * y, 30));
      // The covariance correction works from the predicted values.
      p00 = sat32(n00 - rnd_shr(k0 * n00, 30));
      p01 = sat32(n01 - rnd_shr(k0 * n01, 30));
      p10 = sat32(n10 - rnd_shr(k1 * n00, 30));
      p11 = sat32(n11 - rnd_shr(k1 * n01, 30));
    end
    res.angle = ang[31:0];
    res.rate  = rate[31:0];
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, exp_v);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    filt_out_t e;
    if (rst) begin
      expected_q.delete();
      q_angle <= ANGLE_NOISE_RST;
      q_bias  <= BIAS_NOISE_RST;
      r_meas  <= MEAS_NOISE_RST;
      ang = 0; bias = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ANGLE_NOISE: q_angle <= pwdata[23:0];
          REG_BIAS_NOISE:  q_bias  <= pwdata[23:0];
          REG_MEAS_NOISE:  r_meas  <= pwdata[23:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_q.push_back(filter_step(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $realtime);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (m_tdata[31:0] !== e.angle) report("filtered_angle", m_tdata[31:0], e.angle);
          if (m_tdata[63:32] !== e.rate) report("corrected_rate", m_tdata[63:32], e.rate);
        end
      end
    end
  end

endmodule

FILE: dv/tb_angle_kalman_filter_1d.sv
`timescale 1ns / 1ps

module tb_angle_kalman_filter_1d;
  import akf_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;   // measured_angle, gyro_rate, time_step
  logic        s_tuser = 0;    // mode
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;        // filtered_angle, corrected_rate
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          send_idle = 0, recv_stall = 0;
  int          quiet_cycles = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  angle_kalman_filter_1d DUT (.*);

  akf_checker u_checker (.*);

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_angle_kalman_filter_1d failed");
      $finish;
    end
  end

  task automatic write_noise(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= {8'd0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Drain all outstanding results, then let the block settle before config changes.
  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send(input logic mode, input logic [31:0] meas, input logic [31:0] gyro,
                      input logic [23:0] dt);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= mode;
    s_tdata  <= {dt, gyro, meas};
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly realistic sample streams, with occasional full-range noise.
  task automatic send_random();
    logic [31:0] meas, gyro;
    logic [23:0] dt;
    int sel;
    sel = $urandom_range(99);
    meas = (sel < 80) ? 32'($signed($urandom_range(0, 180 << 17)) - (90 << 16)) : $urandom;
    gyro = (sel < 80) ? 32'($signed($urandom_range(0, 500 << 17)) - (250 << 16)) : $urandom;
    dt   = (sel < 85) ? 24'($urandom_range(1 << 19)) : 24'($urandom);
    send($urandom_range(99) < 4, meas, gyro, dt);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed items: extremes, both modes, negative innovation variance.
    send(0, 32'h0, 32'h0, 24'h0);
    send(0, 32'h7fffffff, 32'h7fffffff, 24'hffffff);
    send(0, 32'h80000000, 32'h80000000, 24'hffffff);
    send(0, 32'h7fffffff, 32'h80000000, 24'h800000);
    send(1, 32'h7fffffff, 32'h80000000, 24'h0);
    send(0, 32'h80000000, 32'h7fffffff, 24'h000001);
    send(1, 32'h80000000, 32'h7fffffff, 24'hffffff);
    send(0, 32'h7fffffff, 32'h0, 24'hffffff);
    send(1, 32'h0, 32'h0, 24'h0);
    repeat (6) send(0, 32'h00010000, 32'h00050000, 24'hffffff);
    send(0, 32'hffff0000, 32'hfffb0000, 24'h5a5a5a);
    send(0, 32'h55555555, 32'haaaaaaaa, 24'ha5a5a5);
    send(0, 32'haaaaaaaa, 32'h55555555, 24'h5a5a5a);
    drain();
    write_noise(REG_ANGLE_NOISE, 24'd0);
    write_noise(REG_BIAS_NOISE, 24'hffffff);
    write_noise(REG_MEAS_NOISE, 24'd1);
    send(1, 32'h0, 32'h0, 24'h0);
    repeat (4) send(0, 32'h00100000, 32'h0, 24'hffffff);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          write_noise(REG_ANGLE_NOISE, ANGLE_NOISE_RST);
          write_noise(REG_BIAS_NOISE, BIAS_NOISE_RST);
          write_noise(REG_MEAS_NOISE, MEAS_NOISE_RST);
        end
        1: begin
          write_noise(REG_ANGLE_NOISE, 24'hffffff);
          write_noise(REG_BIAS_NOISE, 24'd0);
          write_noise(REG_MEAS_NOISE, 24'hffffff);
        end
        default: begin
          write_noise(REG_ANGLE_NOISE, 24'($urandom));
          write_noise(REG_BIAS_NOISE, 24'($urandom));
          write_noise(REG_MEAS_NOISE, 24'($urandom_range(24'hffffff, 1)));
        end
      endcase
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 67) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 67) : 0;
      for (int i = 0; i < 256; i++) begin
        if (ph == 2 && i == 100) begin
          s_tvalid <= 0;
          while (pending != 0) @(posedge clk);
        end
        send_random();
      end
    end
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_angle_kalman_filter_1d passed");
    end else begin
      $display("tb_angle_kalman_filter_1d failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/akf_pkg.sv
rtl/akf_div.sv
rtl/akf_datapath.sv
rtl/akf_ctrl.sv
rtl/angle_kalman_filter_1d.sv
dv/akf_checker.sv
dv/tb_angle_kalman_filter_1d.sv
